// File: design/hex_byte_dot_matrix_writer_defines.svh
// Assertion macros for the hex byte dot-matrix writer.
// Included by the top level; depends on nothing else.
`ifndef HEX_BYTE_DOT_MATRIX_WRITER_DEFINES_SVH
`define HEX_BYTE_DOT_MATRIX_WRITER_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define HBDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define HBDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hbdm_pkg.sv
// Shared types, driver constants and the hex font for the dot-matrix writer.
// Used by every module of the block; depends on nothing.
package hbdm_pkg;

    typedef struct packed {
        logic [7:0] value;
        logic       high_point;
        logic       low_point;
        logic [1:0] position;
    } t_cmd;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic       bad_position;
        logic       last;
    } t_res;

    // A classified command as it waits between the front and the back.
    typedef struct packed {
        logic       bad;
        logic [6:0] addr;
        logic [3:0] lo;
        logic [3:0] hi;
        logic       high_point;
        logic       low_point;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef logic [4:0] t_step;

    localparam logic [6:0] BASE_ADDR  = 7'h61;
    localparam logic [1:0] POS_MAX    = 2'd2;
    localparam logic [7:0] REG_RESET  = 8'hFF;
    localparam logic [7:0] REG_MODE   = 8'h00;
    localparam logic [7:0] MODE_VAL   = 8'h18;
    localparam logic [7:0] REG_ROW0   = 8'h01;
    localparam logic [7:0] REG_COL0   = 8'h0E;
    localparam logic [7:0] REG_POINT  = 8'h15;
    localparam logic [7:0] REG_UPDATE = 8'h0C;
    localparam logic [7:0] POINT_ON   = 8'hFF;
    localparam logic [7:0] ROW_POINT  = 8'h80;

    localparam t_step STEP_RESET    = 5'd0;
    localparam t_step STEP_MODE     = 5'd1;
    localparam t_step STEP_ROW0     = 5'd2;
    localparam t_step STEP_ROW_LAST = 5'd8;
    localparam t_step STEP_COL0     = 5'd9;
    localparam t_step STEP_COL_LAST = 5'd15;
    localparam t_step STEP_POINT    = 5'd16;
    localparam t_step STEP_UPDATE   = 5'd17;

    // Seven 4-bit font rows of one hex digit, row 0 in the low nibble.
    function automatic logic [27:0] font_rows(input logic [3:0] nib);
        logic [27:0] rows;
        case (nib)
            4'h0:    rows = 28'h6999996;
            4'h1:    rows = 28'h1111111;
            4'h2:    rows = 28'hF88611E;
            4'h3:    rows = 28'hE11611E;
            4'h4:    rows = 28'h111F998;
            4'h5:    rows = 28'hE11E88F;
            4'h6:    rows = 28'h699E886;
            4'h7:    rows = 28'h111111F;
            4'h8:    rows = 28'h6996996;
            4'h9:    rows = 28'h6117996;
            4'hA:    rows = 28'h999F996;
            4'hB:    rows = 28'hE99E99E;
            4'hC:    rows = 28'h7888887;
            4'hD:    rows = 28'hE99999E;
            4'hE:    rows = 28'hF88F88F;
            4'hF:    rows = 28'h888E88F;
            default: rows = 28'h0;
        endcase
        return rows;
    endfunction

endpackage

// File: design/hbdm_front.sv
// Front end: takes commands and classifies them into queue entries.
// Depends on hbdm_pkg.
module hbdm_front (
    input  logic               i_start,
    input  hbdm_pkg::t_cmd     i_cmd,
    input  logic               i_full,
    output logic               o_push,
    output hbdm_pkg::t_entry   o_entry
);
    import hbdm_pkg::*;

    // A command is taken whenever the queue has room.
    assign o_push = i_start && !i_full;

    always_comb begin
        o_entry.bad        = (i_cmd.position > POS_MAX);
        o_entry.addr       = BASE_ADDR + {5'd0, i_cmd.position};
        o_entry.lo         = i_cmd.value[3:0];
        o_entry.hi         = i_cmd.value[7:4];
        o_entry.high_point = i_cmd.high_point;
        o_entry.low_point  = i_cmd.low_point;
    end

endmodule

// File: design/hbdm_queue.sv
// Small first-in first-out queue of classified commands.
// Depends on hbdm_pkg.
module hbdm_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hbdm_pkg::t_q_ctrl    i_ctrl,
    input  hbdm_pkg::t_entry     i_entry,
    output hbdm_pkg::t_entry     o_head,
    output hbdm_pkg::t_q_status  o_status
);
    import hbdm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_ctrl.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_ctrl.push && i_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head   = r_slots[r_rd_ptr];
    assign o_status = '{valid: (r_count != '0), full: (r_count == CNT_FULL)};

endmodule

// File: design/hbdm_back.sv
// Back end: walks the head entry through the 18-write driver sequence, or a single error write.
// Depends on hbdm_pkg.
module hbdm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbdm_pkg::t_entry   i_head,
    input  logic               i_valid,
    output logic               o_pop,
    output logic               o_strobe,
    output hbdm_pkg::t_res     o_res
);
    import hbdm_pkg::*;

    t_step      r_step, n_step;
    logic       r_strobe;
    t_res       r_res, n_res;
    logic [27:0] lo_rows, hi_rows;
    logic [2:0] row_idx, col_idx;
    logic [1:0] col_bit;
    logic       col_used;
    logic [4:0] row_bits;
    logic [6:0] col_bits;

    always_comb begin
        lo_rows  = font_rows(i_head.lo);
        hi_rows  = font_rows(i_head.hi);
        row_idx  = 3'(r_step - STEP_ROW0);
        col_idx  = 3'(r_step - STEP_COL0);
        // Column c looks at font bit 4-c; only columns one to four land in the font.
        col_used = (col_idx >= 3'd1) && (col_idx <= 3'd4);
        col_bit  = 2'(3'd4 - col_idx);
        row_bits = '0;
        if (row_idx < 3'd7) begin
            row_bits = {lo_rows[4*row_idx], lo_rows[4*row_idx+1], lo_rows[4*row_idx+2],
                        lo_rows[4*row_idx+3], 1'b0};
        end
        for (int r = 0; r < 7; r++) begin
            col_bits[r] = col_used && hi_rows[4*r + int'(col_bit)];
        end
    end

    always_comb begin
        n_res.device_address = i_head.addr;
        n_res.bad_position   = 1'b0;
        n_res.last           = 1'b0;
        n_res.register_index = REG_RESET;
        n_res.write_value    = 8'h00;
        case (r_step)
            STEP_RESET: begin
                n_res.register_index = REG_RESET;
            end
            STEP_MODE: begin
                n_res.register_index = REG_MODE;
                n_res.write_value    = MODE_VAL;
            end
            STEP_POINT: begin
                n_res.register_index = REG_POINT;
                n_res.write_value    = i_head.high_point ? POINT_ON : 8'h00;
            end
            STEP_UPDATE: begin
                n_res.register_index = REG_UPDATE;
                n_res.last           = 1'b1;
            end
            default: begin
                if (r_step inside {[STEP_ROW0:STEP_ROW_LAST]}) begin
                    n_res.register_index = REG_ROW0 + {5'd0, row_idx};
                    n_res.write_value    = {3'b000, row_bits}
                                           | (i_head.low_point ? ROW_POINT : 8'h00);
                end else begin
                    n_res.register_index = REG_COL0 + {5'd0, col_idx};
                    n_res.write_value    = {1'b0, col_bits};
                end
            end
        endcase
        if (i_head.bad) begin
            n_res = '0;
            n_res.bad_position = 1'b1;
            n_res.last         = 1'b1;
        end
    end

    assign o_pop = i_valid && (i_head.bad || (r_step == STEP_UPDATE));

    always_comb begin
        n_step = r_step;
        if (o_pop) begin
            n_step = STEP_RESET;
        end else if (i_valid) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// File: design/hex_byte_dot_matrix_writer.sv
// The first write of a command passes through the queue and the registered sequencer output.
// A command with a valid position takes 18 writes, a bad one a single error write;
// the sequencer emits one write per cycle and is the only limit on the rate.
// Commands are taken back to back until the command queue is full (busy high).
// Reset (synchronous, active low) empties the queue and idles the sequencer.
// Results are never held off; each write is shown for exactly one cycle.
module hex_byte_dot_matrix_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  hbdm_pkg::t_cmd  i_cmd,
    output logic            busy,
    output logic            o_strobe,
    output hbdm_pkg::t_res  o_res
);
    import hbdm_pkg::*;

    `include "hex_byte_dot_matrix_writer_defines.svh"

    // The front classifies each command (position check, device address, nibble
    // split) and pushes it into the queue in the cycle it is taken.
    t_entry    front_entry;
    t_entry    head_entry;
    t_q_ctrl   q_ctrl;
    t_q_status q_status;
    logic      front_push;
    logic      back_pop;

    hbdm_front u_front (
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_full  (q_status.full),
        .o_push  (front_push),
        .o_entry (front_entry)
    );

    // The queue decouples intake from the write sequencer, so a new command can
    // be accepted while the previous one is still being written out.
    hbdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (q_ctrl),
        .i_entry  (front_entry),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    assign q_ctrl = '{push: front_push, pop: back_pop};

    // The back steps through the register writes of the head entry, one per
    // cycle, into a registered output, and pops the entry on its last write.
    hbdm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_valid  (q_status.valid),
        .o_pop    (back_pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Busy only means there is no room left in the queue.
    assign busy = q_status.full;

    // Terms used by the checks below.
    logic mid_seq;
    logic err_beat;
    logic err_beat_ok;
    logic seq_end;
    logic ends_update;
    logic good_beat;
    logic good_addr;

    assign mid_seq     = o_strobe && !o_res.last;
    assign err_beat    = o_strobe && o_res.bad_position;
    assign err_beat_ok = o_res.last && (o_res.device_address == '0)
                         && (o_res.register_index == '0);
    assign seq_end     = o_strobe && o_res.last && !o_res.bad_position;
    assign ends_update = (o_res.register_index == REG_UPDATE);
    assign good_beat   = o_strobe && !o_res.bad_position;
    assign good_addr   = (o_res.device_address >= BASE_ADDR)
                         && (o_res.device_address <= BASE_ADDR + 7'(POS_MAX));

    // A sequence, once started, runs without gaps until its last write.
    `HBDM_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, mid_seq, o_strobe, "gap inside a write sequence")
    // A bad position yields a single all-zero error beat.
    `HBDM_ASSERT_NOW(a_bad_single, i_clk, i_rst_n, err_beat, err_beat_ok, "malformed error beat")
    // A good sequence ends with the update strobe.
    `HBDM_ASSERT_NOW(a_last_update, i_clk, i_rst_n, seq_end, ends_update, "no update at end")
    // Every good write targets one of the three matrix devices.
    `HBDM_ASSERT_NOW(a_addr_range, i_clk, i_rst_n, good_beat, good_addr, "bad device address")

endmodule

// File: test/hex_byte_dot_matrix_writer_tb.sv
// Self-checking testbench for the hex byte dot-matrix writer: it predicts every
// register write of each accepted command and compares the block's writes in order.
// Depends on hbdm_pkg and on the hex_byte_dot_matrix_writer RTL.
module hex_byte_dot_matrix_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbdm_pkg::*;

    // The watchdog ends the run once its idle count reaches this limit while no beat
    // moves on either side.
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_COMMANDS = 210;
    localparam int MAX_GAP         = 20;
    // Once nothing is expected, the bench keeps watching this long for stray writes.
    localparam int DRAIN_CYCLES    = 24;

    // The scoreboard renders each accepted command into the writes that the
    // driver should see, and checks the block's writes against them in order.
    class dot_matrix_scoreboard;
        t_res expected_writes[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // One row of the 7x4 hex font. Row 0 sits in the top nibble, so each
        // glyph reads from top to bottom as it is written here.
        function logic [3:0] glyph_row(input logic [3:0] digit, input int row);
            logic [27:0] rows;
            case (digit)
                4'h0:    rows = 28'h6999996;
                4'h1:    rows = 28'h1111111;
                4'h2:    rows = 28'hE11688F;
                4'h3:    rows = 28'hE11611E;
                4'h4:    rows = 28'h899F111;
                4'h5:    rows = 28'hF88E11E;
                4'h6:    rows = 28'h688E996;
                4'h7:    rows = 28'hF111111;
                4'h8:    rows = 28'h6996996;
                4'h9:    rows = 28'h6997116;
                4'hA:    rows = 28'h699F999;
                4'hB:    rows = 28'hE99E99E;
                4'hC:    rows = 28'h7888887;
                4'hD:    rows = 28'hE99999E;
                4'hE:    rows = 28'hF88F88F;
                default: rows = 28'hF88E888;
            endcase
            return rows[27 - 4 * row -: 4];
        endfunction

        function void push_write(input logic [6:0] addr, input logic [7:0] index,
                                 input logic [7:0] data, input logic is_last);
            t_res w;
            w.device_address = addr;
            w.register_index = index;
            w.write_value    = data;
            w.bad_position   = 1'b0;
            w.last           = is_last;
            expected_writes.push_back(w);
        endfunction

        function void note_command(input t_cmd c);
            logic [6:0] addr;
            logic [3:0] bits;
            logic [7:0] column;
            t_res       w;
            if (c.position > POS_MAX) begin
                // An invalid position gives one error write and nothing else.
                w              = '0;
                w.bad_position = 1'b1;
                w.last         = 1'b1;
                expected_writes.push_back(w);
                return;
            end
            addr = BASE_ADDR + 7'(c.position);
            push_write(addr, REG_RESET, 8'h00, 1'b0);
            push_write(addr, REG_MODE, MODE_VAL, 1'b0);
            // Low digit: each font row is mirrored into five bits, and the
            // decimal point rides on bit 7 of every row.
            for (int r = 0; r < 7; r++) begin
                bits = glyph_row(c.value[3:0], r);
                push_write(addr, REG_ROW0 + 8'(r),
                           (c.low_point ? ROW_POINT : 8'h00) |
                           {3'b000, bits[0], bits[1], bits[2], bits[3], 1'b0},
                           1'b0);
            end
            // High digit: column c looks at font bit 4 - c, so only columns 1 to 4
            // can ever light; the outer ones stay dark.
            for (int col = 0; col < 7; col++) begin
                column = 8'h00;
                if (col >= 1 && col <= 4) begin
                    for (int r = 0; r < 7; r++) begin
                        bits      = glyph_row(c.value[7:4], r);
                        column[r] = bits[4 - col];
                    end
                end
                push_write(addr, REG_COL0 + 8'(col), column, 1'b0);
            end
            push_write(addr, REG_POINT, c.high_point ? POINT_ON : 8'h00, 1'b0);
            push_write(addr, REG_UPDATE, 8'h00, 1'b1);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_write(input t_res got);
            t_res want;
            if (expected_writes.size() == 0) begin
                $display("%0t: write with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_writes.pop_front();
            compare_field("device_address", want.device_address, got.device_address);
            compare_field("register_index", want.register_index, got.register_index);
            compare_field("write_value", want.write_value, got.write_value);
            compare_field("bad_position", want.bad_position, got.bad_position);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd cmd;
    logic busy;
    logic strobe;
    t_res res;
    int   idle_cycles;

    dot_matrix_scoreboard board;

    hex_byte_dot_matrix_writer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_strobe (strobe),
        .o_res    (res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Both beats are sampled at the rising edge, where the inputs have been
    // steady since the falling edge and the outputs still hold their old values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_command(cmd);
            end
            if (strobe) begin
                board.check_write(res);
            end
        end
    end

    // The watchdog restarts on every beat in either direction and ends a run
    // that has stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one command from the next falling edge on and holds it until the
    // block takes it. Start stays high, so back-to-back calls form a burst.
    task automatic send_command(input t_cmd c);
        @(negedge i_clk);
        start <= 1'b1;
        cmd   <= c;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Drops start for the given number of cycles, with junk on the command bus
    // that the block has to ignore.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            cmd   <= t_cmd'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_cmd random_command();
        t_cmd c;
        c            = t_cmd'($urandom);
        // Mostly valid positions, so that most commands run the full sequence.
        c.position   = ($urandom_range(0, 6) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        return c;
    endfunction

    initial begin
        t_cmd c;
        int   sent;
        int   burst;
        int   gap;

        board       = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, sent back to back so that the queue fills up. Every
        // digit appears once as the low and once as the high nibble, on every
        // valid position, with all four point combinations.
        for (int k = 0; k < 16; k++) begin
            c.value      = {4'(k), 4'(15 - k)};
            c.high_point = k[0];
            c.low_point  = k[1];
            c.position   = 2'(k % 3);
            send_command(c);
        end
        // Blank and full bytes, and an invalid position with every other
        // field at both extremes.
        c = '{value: 8'h00, high_point: 1'b0, low_point: 1'b0, position: 2'd0};
        send_command(c);
        c = '{value: 8'hFF, high_point: 1'b1, low_point: 1'b1, position: 2'd2};
        send_command(c);
        c = '{value: 8'hFF, high_point: 1'b1, low_point: 1'b1, position: 2'd3};
        send_command(c);
        c = '{value: 8'h00, high_point: 1'b0, low_point: 1'b0, position: 2'd3};
        send_command(c);
        c = '{value: 8'h5A, high_point: 1'b1, low_point: 1'b0, position: 2'd1};
        send_command(c);
        hold_off(30);

        // Random part in bursts of random length. About a quarter of the gaps
        // are empty, which gives long stretches with start held high.
        sent = 0;
        while (sent < RANDOM_COMMANDS) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_COMMANDS; b++) begin
                send_command(random_command());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            hold_off(gap);
        end
        hold_off(1);

        // The watchdog covers a block that never delivers the rest.
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
